[hw/rtl/mwvw_pkg.sv]
`default_nettype none
package mwvw_pkg;

    localparam int SEQ_W      = 32;
    localparam int WIRE_W     = 3;
    localparam int PAY_W      = 64;
    localparam int VOTE_W     = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam int THR_W      = 3;

    localparam logic [VOTE_W-1:0]     VOTE_MAX   = 4'd15;
    localparam logic [CFG_DATA_W-1:0] WIRES_RST  = 4'd8;
    localparam logic [THR_W-1:0]      THRESH_RST = 3'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIRES  = 1'b0,
        CFG_THRESH = 1'b1
    } t_cfg_reg;

endpackage
`default_nettype wire

[hw/rtl/mwvw_match.sv]
`default_nettype none
module mwvw_match import mwvw_pkg::*; #(
    parameter int MAX_WIRES    = 8,
    parameter int PAYLOAD_BITS = 64
) (
    input  wire logic [MAX_WIRES*(PAYLOAD_BITS+VOTE_W+MAX_WIRES)-1:0] i_line,
    input  wire logic [MAX_WIRES-1:0]                 i_valid,
    input  wire logic [PAYLOAD_BITS-1:0]              i_pay,
    input  wire logic [$clog2(MAX_WIRES+1)-1:0]       i_count,
    output logic                                      o_hit,
    output logic                                      o_empty,
    output logic [(MAX_WIRES > 1 ? $clog2(MAX_WIRES) : 1)-1:0] o_slot
);
    localparam int SLOT_W = PAYLOAD_BITS + VOTE_W + MAX_WIRES;
    localparam int SI_W   = (MAX_WIRES > 1) ? $clog2(MAX_WIRES) : 1;

    logic [MAX_WIRES-1:0] w_cand;
    logic                 w_found;

    // slots fill in order, so the first free or equal slot decides
    always_comb begin
        w_found = 1'b0;
        o_slot  = '0;
        for (int k = 0; k < MAX_WIRES; k++) begin
            w_cand[k] = (k < int'(i_count)) &&
                        (!i_valid[k] || (i_line[k*SLOT_W +: PAYLOAD_BITS] == i_pay));
        end
        for (int k = MAX_WIRES - 1; k >= 0; k--) begin
            if (w_cand[k]) begin
                w_found = 1'b1;
                o_slot  = SI_W'(k);
            end
        end
        o_hit   = w_found && i_valid[o_slot];
        o_empty = w_found && !i_valid[o_slot];
    end

endmodule
`default_nettype wire

[hw/rtl/multi_wire_vote_window.sv]
`default_nettype none
// Channel   Handshake                 Payload
// request   start / busy              i_seq_number, i_wire_index, i_payload_word
// result    o_result_valid (strobe)   o_accepted_seq, o_accepted_payload, o_window_base
// config    i_cfg_we                  i_cfg_index, i_cfg_data
//
// A request first reads its row from the row memory, then is evaluated and
// written back. A request that finishes the oldest row walks finished rows one
// per cycle. Requests dropped at the window, wire or finished check never leave
// the idle state. Synchronous reset clears valid bits, finished marks and the
// base at once; no clearing pass. The result strobe lasts one cycle and cannot
// be stalled.
module multi_wire_vote_window import mwvw_pkg::*; #(
    parameter int WINDOW_ROWS  = 16,
    parameter int MAX_WIRES    = 8,
    parameter int PAYLOAD_BITS = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [SEQ_W-1:0]      i_seq_number,
    input  wire logic [WIRE_W-1:0]     i_wire_index,
    input  wire logic [PAY_W-1:0]      i_payload_word,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_result_valid,
    output logic [SEQ_W-1:0]           o_accepted_seq,
    output logic [PAY_W-1:0]           o_accepted_payload,
    output logic [SEQ_W-1:0]           o_window_base
);
    localparam int RW     = (WINDOW_ROWS > 1) ? $clog2(WINDOW_ROWS) : 1;
    localparam int SI_W   = (MAX_WIRES > 1) ? $clog2(MAX_WIRES) : 1;
    localparam int CNT_W  = $clog2(MAX_WIRES + 1);
    localparam int STEP_W = $clog2(WINDOW_ROWS + 1);
    localparam int SLOT_W = PAYLOAD_BITS + VOTE_W + MAX_WIRES;
    localparam int LINE_W = MAX_WIRES * SLOT_W;

    typedef enum logic [1:0] {S_IDLE, S_EVAL, S_ADV} t_state;

    t_state r_state, n_state;
    logic [CFG_DATA_W-1:0] r_wires;
    logic [THR_W-1:0]      r_thr;
    logic [MAX_WIRES-1:0]  r_valid [WINDOW_ROWS];
    logic [MAX_WIRES-1:0]  n_valid [WINDOW_ROWS];
    logic [WINDOW_ROWS-1:0] r_fin, n_fin;
    logic [SEQ_W-1:0]      r_base_seq, n_base_seq;
    logic [RW-1:0]         r_base_row, n_base_row;
    logic [RW-1:0]         r_row, n_row;
    logic [RW-1:0]         r_idx, n_idx;
    logic [STEP_W-1:0]     r_step, n_step;
    logic                  r_off0, n_off0;
    logic [SEQ_W-1:0]      r_seq;
    logic [WIRE_W-1:0]     r_wire;
    logic [PAYLOAD_BITS-1:0] r_pay;
    logic                  n_emit;

    logic [LINE_W-1:0]     mem [WINDOW_ROWS];
    logic [LINE_W-1:0]     r_rd;
    logic [LINE_W-1:0]     w_line;
    logic                  w_we;

    logic [CNT_W-1:0]      w_cnt;
    logic [SEQ_W-1:0]      w_off;
    logic [RW:0]           w_sum;
    logic [RW-1:0]         w_row;
    logic                  w_take;
    logic                  w_hit, w_empty;
    logic [SI_W-1:0]       w_slot;
    logic [SLOT_W-1:0]     w_sel;
    logic [VOTE_W-1:0]     w_votes, w_nv;
    logic [MAX_WIRES-1:0]  w_voters, w_bit;
    logic                  w_dup, w_acc;
    logic [RW-1:0]         w_next_row, w_next_idx;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        if (r_wires == '0) begin
            w_cnt = CNT_W'(1);
        end else if (int'(r_wires) > MAX_WIRES) begin
            w_cnt = CNT_W'(MAX_WIRES);
        end else begin
            w_cnt = CNT_W'(r_wires);
        end
        w_off = i_seq_number - r_base_seq;
        w_sum = {1'b0, r_base_row} + {1'b0, w_off[RW-1:0]};
        if (w_sum >= (RW+1)'(WINDOW_ROWS)) begin
            w_row = RW'(w_sum - (RW+1)'(WINDOW_ROWS));
        end else begin
            w_row = w_sum[RW-1:0];
        end
        w_take = (w_off < SEQ_W'(WINDOW_ROWS)) && (int'(i_wire_index) < int'(w_cnt)) &&
                 !r_fin[w_row];
    end

    mwvw_match #(
        .MAX_WIRES    (MAX_WIRES),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_match (
        .i_line  (r_rd),
        .i_valid (r_valid[r_row]),
        .i_pay   (r_pay),
        .i_count (w_cnt),
        .o_hit   (w_hit),
        .o_empty (w_empty),
        .o_slot  (w_slot)
    );

    always_comb begin
        w_sel    = r_rd[w_slot*SLOT_W +: SLOT_W];
        w_votes  = w_sel[PAYLOAD_BITS +: VOTE_W];
        w_voters = w_sel[PAYLOAD_BITS+VOTE_W +: MAX_WIRES];
        for (int k = 0; k < MAX_WIRES; k++) begin
            w_bit[k] = (k == int'(r_wire));
        end
        w_dup = |(w_voters & w_bit);
        w_nv  = (w_votes == VOTE_MAX) ? VOTE_MAX : w_votes + VOTE_W'(1);
        w_acc = w_nv > {1'b0, r_thr};
        w_line = r_rd;
        if (w_empty) begin
            w_line[w_slot*SLOT_W +: SLOT_W] = {w_bit, VOTE_W'(1), r_pay};
        end else begin
            w_line[w_slot*SLOT_W +: SLOT_W] =
                {w_voters | w_bit, w_nv, w_sel[PAYLOAD_BITS-1:0]};
        end
        w_we = (r_state == S_EVAL) && (w_empty || (w_hit && !w_dup && !w_acc));
        w_next_row = (r_row == RW'(WINDOW_ROWS - 1)) ? '0 : r_row + RW'(1);
        w_next_idx = (r_idx == RW'(WINDOW_ROWS - 1)) ? '0 : r_idx + RW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[r_row] <= w_line;
        end
        r_rd <= mem[w_row];
    end

    always_comb begin
        n_state    = r_state;
        n_valid    = r_valid;
        n_fin      = r_fin;
        n_base_seq = r_base_seq;
        n_base_row = r_base_row;
        n_row      = r_row;
        n_idx      = r_idx;
        n_step     = r_step;
        n_off0     = r_off0;
        n_emit     = 1'b0;
        case (r_state)
            S_IDLE: begin
                n_row  = w_row;
                n_off0 = (w_off == '0);
                if (start && w_take) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_IDLE;
                if (w_empty) begin
                    n_valid[r_row][w_slot] = 1'b1;
                end else if (w_hit && !w_dup && w_acc) begin
                    n_valid[r_row] = '0;
                    if (r_off0) begin
                        // oldest row: its mark is dropped straight away
                        n_step  = STEP_W'(1);
                        n_idx   = w_next_row;
                        n_state = S_ADV;
                    end else begin
                        n_fin[r_row] = 1'b1;
                        n_emit       = 1'b1;
                    end
                end
            end
            S_ADV: begin
                if (!r_fin[r_idx]) begin
                    n_base_row = r_idx;
                    n_base_seq = r_base_seq + SEQ_W'(r_step);
                    n_emit     = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    n_fin[r_idx] = 1'b0;
                    if (r_step == STEP_W'(WINDOW_ROWS - 1)) begin
                        // full sweep: base row stays
                        n_base_seq = r_base_seq + SEQ_W'(WINDOW_ROWS);
                        n_emit     = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        n_step = r_step + STEP_W'(1);
                        n_idx  = w_next_idx;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_seq  <= i_seq_number;
            r_wire <= i_wire_index;
            r_pay  <= i_payload_word[PAYLOAD_BITS-1:0];
        end
        r_row  <= n_row;
        r_idx  <= n_idx;
        r_step <= n_step;
        r_off0 <= n_off0;
        if (n_emit) begin
            o_accepted_seq     <= r_seq;
            o_accepted_payload <= PAY_W'(r_pay);
            o_window_base      <= n_base_seq;
        end
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_wires        <= WIRES_RST;
            r_thr          <= THRESH_RST;
            r_valid        <= '{default: '0};
            r_fin          <= '0;
            r_base_seq     <= '0;
            r_base_row     <= '0;
            o_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_valid        <= n_valid;
            r_fin          <= n_fin;
            r_base_seq     <= n_base_seq;
            r_base_row     <= n_base_row;
            o_result_valid <= n_emit;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WIRES:  r_wires <= i_cfg_data;
                    CFG_THRESH: r_thr   <= i_cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps

import mwvw_pkg::*;

typedef struct {
    logic [SEQ_W-1:0] seq;
    logic [PAY_W-1:0] payload;
    logic [SEQ_W-1:0] base;
} t_vote_result;

class vote_scoreboard;
    localparam int ROWS  = 16;
    localparam int WIRES = 8;

    logic [CFG_DATA_W-1:0] wires_reg;
    logic [THR_W-1:0]      thresh_reg;
    bit                    slot_used [ROWS*WIRES];
    logic [PAY_W-1:0]      slot_word [ROWS*WIRES];
    logic [VOTE_W-1:0]     slot_count[ROWS*WIRES];
    logic [WIRES-1:0]      slot_mask [ROWS*WIRES];
    bit                    row_done  [ROWS];
    logic [SEQ_W-1:0]      base_seq;
    logic [3:0]            base_row;
    t_vote_result          agreed_q[$];
    int                    errors;
    int                    requests;
    int                    checked;
    int                    sweeps;

    function new();
        wires_reg  = WIRES_RST;
        thresh_reg = THRESH_RST;
        foreach (slot_used[i]) begin
            slot_used[i]  = 0;
            slot_count[i] = '0;
            slot_mask[i]  = '0;
        end
        foreach (row_done[i]) row_done[i] = 0;
        base_seq = '0;
        base_row = '0;
        errors   = 0;
        requests = 0;
        checked  = 0;
        sweeps   = 0;
    endfunction

    function void write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_WIRES) wires_reg = data;
        else thresh_reg = data[THR_W-1:0];
    endfunction

    function int wire_count();
        if (wires_reg == 0) return 1;
        if (wires_reg > WIRES) return WIRES;
        return wires_reg;
    endfunction

    function void walk_base();
        logic [3:0] idx;
        row_done[base_row] = 0;
        for (int j = 1; j < ROWS; j++) begin
            idx = base_row + j[3:0];
            if (!row_done[idx]) begin
                base_row = idx;
                base_seq += j;
                return;
            end
            row_done[idx] = 0;
        end
        // every row was finished: keep the row, move a whole window on
        base_seq += ROWS;
        sweeps++;
    endfunction

    function void note_request(logic [SEQ_W-1:0] seq, logic [WIRE_W-1:0] wire_idx,
                               logic [PAY_W-1:0] word);
        logic [SEQ_W-1:0] offset;
        logic [3:0]       row;
        logic [WIRES-1:0] bitm;
        int               n;
        int               s;
        t_vote_result     r;
        requests++;
        n = wire_count();
        offset = seq - base_seq;
        if (offset >= ROWS) return;
        if (wire_idx >= n) return;
        row = base_row + offset[3:0];
        if (row_done[row]) return;
        bitm = WIRES'(1) << wire_idx;
        for (int i = 0; i < n; i++) begin
            s = row * WIRES + i;
            if (!slot_used[s]) begin
                slot_used[s]  = 1;
                slot_word[s]  = word;
                slot_count[s] = VOTE_W'(1);
                slot_mask[s]  = bitm;
                return;
            end
            if (slot_word[s] == word) begin
                if (slot_mask[s] & bitm) return;
                if (slot_count[s] < VOTE_MAX) slot_count[s]++;
                slot_mask[s] |= bitm;
                if (slot_count[s] > thresh_reg) begin
                    for (int k = 0; k < WIRES; k++) begin
                        slot_used[row*WIRES+k]  = 0;
                        slot_count[row*WIRES+k] = '0;
                        slot_mask[row*WIRES+k]  = '0;
                    end
                    row_done[row] = 1;
                    if (offset == 0) walk_base();
                    r.seq     = seq;
                    r.payload = word;
                    r.base    = base_seq;
                    agreed_q.push_back(r);
                end
                return;
            end
        end
    endfunction

    function void check_result(logic [SEQ_W-1:0] seq, logic [PAY_W-1:0] word,
                               logic [SEQ_W-1:0] base);
        t_vote_result r;
        if (agreed_q.size() == 0) begin
            $error("unexpected result: seq %h payload %h base %h", seq, word, base);
            errors++;
            return;
        end
        r = agreed_q.pop_front();
        checked++;
        if (seq !== r.seq) begin
            $error("accepted_seq: expected %h, got %h", r.seq, seq);
            errors++;
        end
        if (word !== r.payload) begin
            $error("accepted_payload: expected %h, got %h", r.payload, word);
            errors++;
        end
        if (base !== r.base) begin
            $error("window_base: expected %h, got %h", r.base, base);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN       = 24;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [SEQ_W-1:0]      i_seq_number;
    logic [WIRE_W-1:0]     i_wire_index;
    logic [PAY_W-1:0]      i_payload_word;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  o_result_valid;
    logic [SEQ_W-1:0]      o_accepted_seq;
    logic [PAY_W-1:0]      o_accepted_payload;
    logic [SEQ_W-1:0]      o_window_base;

    vote_scoreboard votes = new();
    int             cycles = 0;
    int             burst_left = 0;

    multi_wire_vote_window DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_seq_number       (i_seq_number),
        .i_wire_index       (i_wire_index),
        .i_payload_word     (i_payload_word),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_result_valid     (o_result_valid),
        .o_accepted_seq     (o_accepted_seq),
        .o_accepted_payload (o_accepted_payload),
        .o_window_base      (o_window_base)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid)
            votes.check_result(o_accepted_seq, o_accepted_payload, o_window_base);
    end

    task automatic send_packet(logic [SEQ_W-1:0] seq, logic [WIRE_W-1:0] wire_idx,
                               logic [PAY_W-1:0] word);
        start          <= 1'b1;
        i_seq_number   <= seq;
        i_wire_index   <= wire_idx;
        i_payload_word <= word;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        votes.note_request(seq, wire_idx, word);
        burst_left--;
        if (burst_left <= 0) begin
            // mostly short bursts, now and then a long unbroken run
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            if ($urandom_range(0, 3) != 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
        end
    endtask

    task automatic set_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
        start <= 1'b0;
        while (votes.agreed_q.size() != 0 || busy) @(posedge i_clk);
        // dropped requests give no result: let the walk of finished rows end
        repeat (DRAIN) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        votes.write_reg(idx, data);
    endtask

    task automatic vote_group(int off, int spread);
        logic [SEQ_W-1:0]  seq;
        logic [PAY_W-1:0]  word;
        logic [WIRE_W-1:0] order[8];
        logic [WIRE_W-1:0] prev;
        int                n;
        int                k;
        int                pick;
        logic [WIRE_W-1:0] tmp;
        n    = votes.wire_count();
        seq  = votes.base_seq + SEQ_W'(off);
        word = {$urandom(), $urandom()};
        prev = '0;
        for (int i = 0; i < 8; i++) order[i] = WIRE_W'(i);
        for (int i = n - 1; i > 0; i--) begin
            k = $urandom_range(0, i);
            tmp = order[i]; order[i] = order[k]; order[k] = tmp;
        end
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < spread)
                send_packet(seq, order[i], {$urandom(), $urandom()});
            else if (pick == 9 && i > 0)
                send_packet(seq, prev, word);
            else
                send_packet(seq, order[i], word);
            prev = order[i];
        end
    endtask

    task automatic random_traffic(int count);
        int start_count;
        start_count = votes.requests;
        while (votes.requests - start_count < count) begin
            if ($urandom_range(0, 7) == 0)
                send_packet($urandom(), WIRE_W'($urandom_range(0, 7)),
                            {$urandom(), $urandom()});
            else if ($urandom_range(0, 2) == 0)
                vote_group($urandom_range(0, 15), $urandom_range(0, 2));
            else
                vote_group($urandom_range(0, 3), $urandom_range(0, 1));
        end
    endtask

    // finish every later row first, then the oldest, to force a whole-window move
    task automatic sweep_window();
        logic [PAY_W-1:0] word;
        for (int off = 15; off >= 0; off--) begin
            word = {$urandom(), $urandom()};
            send_packet(votes.base_seq + SEQ_W'(off), 3'd0, word);
            send_packet(votes.base_seq + SEQ_W'(off), 3'd1, word);
        end
    endtask

    initial begin
        logic [PAY_W-1:0] ones;
        ones           = '1;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_seq_number   = '0;
        i_wire_index   = '0;
        i_payload_word = '0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_WIRES;
        i_cfg_data     = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // window edges, repeated vote and first agreement on the oldest row
        send_packet(32'hFFFF_FFFF, 3'd7, ones);
        send_packet(32'd16, 3'd0, '0);
        send_packet(32'd0, 3'd0, '0);
        send_packet(32'd0, 3'd0, '0);
        send_packet(32'd0, 3'd7, '0);
        send_packet(32'd0, 3'd1, '0);
        // fill a row with distinct candidates, then overflow it
        for (int w = 0; w < 8; w++) send_packet(32'd3, WIRE_W'(w), 64'(w + 1));
        send_packet(32'd3, 3'd0, 64'd9);
        send_packet(32'd3, 3'd1, 64'd1);
        send_packet(32'd3, 3'd2, 64'd1);
        send_packet(32'd15, 3'd5, ones);
        send_packet(32'd15, 3'd6, ones);

        sweep_window();
        random_traffic(200);

        set_reg(CFG_WIRES, 4'd1);
        set_reg(CFG_THRESH, 4'd0);
        random_traffic(80);
        set_reg(CFG_WIRES, 4'd2);
        random_traffic(150);
        set_reg(CFG_WIRES, 4'd0);
        random_traffic(50);
        set_reg(CFG_WIRES, 4'd15);
        set_reg(CFG_THRESH, 4'd15);
        random_traffic(200);
        set_reg(CFG_WIRES, 4'd3);
        set_reg(CFG_THRESH, 4'd10);
        random_traffic(200);
        set_reg(CFG_WIRES, 4'd6);
        set_reg(CFG_THRESH, 4'd3);
        random_traffic(200);
        set_reg(CFG_WIRES, 4'd8);
        set_reg(CFG_THRESH, 4'd1);
        sweep_window();
        random_traffic(200);

        start <= 1'b0;
        while (votes.agreed_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (votes.agreed_q.size() != 0) begin
            $error("%0d expected results never arrived", votes.agreed_q.size());
            votes.errors++;
        end
        $display("Sent %0d packets over eight register settings; %0d agreements checked.",
                 votes.requests, votes.checked);
        $display("Whole-window base moves seen: %0d.", votes.sweeps);
        if (votes.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
